// ----- rtl/hsfc_pkg.sv -----
// Package for the half/single float converter: field widths, codes and conversion functions.
package hsfc_pkg;

  localparam int ValueW  = 32;
  localparam int ResultW = 32;

  // Direction codes carried on the op field
  typedef enum logic {
    OP_S2H = 1'b0,
    OP_H2S = 1'b1
  } op_t;

  // Single-precision field constants
  localparam logic [7:0]  SglExpMax   = 8'hFF;
  localparam logic [7:0]  SglOvfExp   = 8'd143;  // half exponent would reach 31
  localparam logic [7:0]  SglNormMin  = 8'd113;  // half exponent 1
  localparam logic [7:0]  SglSubMin   = 8'd102;  // half exponent -10
  localparam logic [7:0]  SglRebias   = 8'd112;  // 127 - 15
  localparam logic [7:0]  SubShiftM1  = 8'd125;  // (14 - e) - 1 in raw exponent terms
  localparam logic [7:0]  HalfSubExp  = 8'd113;  // single exponent of 1.x * 2^-14

  // Half-precision field constants
  localparam logic [4:0]  HalfExpMax  = 5'h1F;
  localparam logic [9:0]  HalfQuietM  = 10'h200;

  // Single to half; the half pattern sits in the low 16 bits
  function automatic logic [15:0] single_to_half(input logic [31:0] f);
    logic        sgn;
    logic [7:0]  rexp;
    logic [22:0] mant;
    logic [23:0] m24;
    logic [4:0]  sh_m1;
    logic [23:0] tsh;
    logic [10:0] sub_mag;
    logic [4:0]  e5;
    logic [14:0] nrm_mag;
    logic [15:0] res;
    sgn     = f[31];
    rexp    = f[30:23];
    mant    = f[22:0];
    m24     = {1'b1, mant};
    sh_m1   = 5'(SubShiftM1 - rexp);
    tsh     = m24 >> sh_m1;
    // last bit shifted out is the round bit
    sub_mag = {1'b0, tsh[10:1]} + {10'b0, tsh[0]};
    e5      = 5'(rexp - SglRebias);
    nrm_mag = {e5, 10'b0} + {5'b0, mant[22:13]} + {14'b0, mant[12]};
    if (rexp == SglExpMax) begin
      res = {sgn, HalfExpMax, (mant != 23'b0) ? HalfQuietM : 10'b0};
    end else if (rexp >= SglOvfExp) begin
      res = {sgn, HalfExpMax, 10'b0};
    end else if (rexp < SglSubMin) begin
      res = {sgn, 15'b0};
    end else if (rexp < SglNormMin) begin
      res = {sgn, 4'b0, sub_mag};
    end else begin
      // rounding carry may step into the next exponent or infinity
      res = {sgn, nrm_mag};
    end
    return res;
  endfunction

  // Half to single, exact
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic        sgn;
    logic [4:0]  hexp;
    logic [9:0]  mant;
    logic [3:0]  msb;
    logic [3:0]  lz;
    logic [9:0]  nmant;
    logic [31:0] res;
    sgn  = h[15];
    hexp = h[14:10];
    mant = h[9:0];
    // priority encoder for the leading one of a subnormal mantissa
    msb  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (mant[i]) msb = 4'(i);
    end
    lz    = 4'd10 - msb;
    nmant = 10'(mant << lz);
    if (hexp == 5'd0) begin
      if (mant == 10'b0) begin
        res = {sgn, 31'b0};
      end else begin
        res = {sgn, 8'(HalfSubExp - {4'b0, lz}), nmant, 13'b0};
      end
    end else if (hexp == HalfExpMax) begin
      res = {sgn, SglExpMax, mant, 13'b0};
    end else begin
      res = {sgn, 8'({3'b0, hexp} + SglRebias), mant, 13'b0};
    end
    return res;
  endfunction

endpackage

// ----- rtl/half_single_float_converter_top.sv -----
// Half/single float converter: two-register pipeline with conversion logic between.
//
// Usage:
//   Request channel (req_valid/req_ready) carries op and value; op selects
//   single to half or half to single. Response channel (rsp_valid/rsp_ready)
//   carries result, one transaction per request, in order.
//   A request accepted into the input register is converted and loaded into
//   the result register, from which it shows on rsp_*.
//   Throughput: one transaction per cycle while rsp_ready is high; the
//   conversion is a short path of compares, two barrel shifts, a priority
//   encoder and adds of up to 15 bits between the input and result registers.
//   Reset (rst, synchronous, active high) empties both stages; req_ready is
//   high in the first cycle after reset.
//   Stall: when rsp_ready is low the result holds. The input stage still
//   takes one more transaction, so up to two are held; req_ready drops only
//   when both stages are full and the response side is stalled.
module half_single_float_converter_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic                        op,
  input  logic [hsfc_pkg::ValueW-1:0] value,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [hsfc_pkg::ResultW-1:0] result
);
  import hsfc_pkg::*;

  logic              in_vld;
  logic              in_op;
  logic [ValueW-1:0] in_value;
  logic              out_adv;
  logic [ResultW-1:0] result_next;

  // output stage can load when empty or being drained
  assign out_adv   = !rsp_valid || rsp_ready;
  assign req_ready = !in_vld || out_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req_ready) begin
      in_vld <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      in_op    <= op;
      in_value <= value;
    end
  end

  // conversion
  always_comb begin
    case (op_t'(in_op))
      OP_S2H:  result_next = {16'b0, single_to_half(in_value)};
      OP_H2S:  result_next = half_to_single(in_value[15:0]);
      default: result_next = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_adv) begin
      rsp_valid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_vld) begin
      result <= result_next;
    end
  end

endmodule

// ----- rtl/hsfc_checker.sv -----
// Port-level checker for the half/single float converter, with its bind.
module hsfc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         op,
  input logic [hsfc_pkg::ValueW-1:0]  value,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [hsfc_pkg::ResultW-1:0] result
);
  import hsfc_pkg::*;

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(result))
    else $error("response changed while stalled");

  // empty output stage never blocks requests
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request stalled with empty output stage");

  // an accepted transaction passes the input register and reaches the output if the result register is not stalled
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) ##1 (!rsp_valid || rsp_ready) |=> rsp_valid)
    else $error("transaction did not reach the output");

  // half results carry zero upper bits
  a_half_upper: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (op == OP_S2H)) ##1 (!rsp_valid || rsp_ready)
      |=> result[31:16] == 16'h0)
    else $error("half result has nonzero upper bits");

endmodule

bind half_single_float_converter_top hsfc_checker u_hsfc_checker (.*);
